>>> hw/rtl/mic_sfp_pkg.sv
// ----------------------------------------------------------------------------
// mic_sfp_pkg
// Shared types and constants of the serial frame parser.
// ----------------------------------------------------------------------------
package mic_sfp_pkg;

  localparam int MAX_FRAME_DEF = 1024;

  localparam int BYTE_W    = 8;
  localparam int ID_W      = 16;
  localparam int LEN_W     = 16;
  localparam int PLEN_W    = 10;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;
  localparam int TOT_W     = 17;

  localparam int HDR_BYTES = 7;

  localparam logic [BYTE_W-1:0] WAKE_TYPE      = 8'h04;
  localparam logic [BYTE_W-1:0] HEADER_RST     = 8'd165;
  localparam logic [BYTE_W-1:0] USER_ID_RST    = 8'd1;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DROP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_ID = 1'b1;

  localparam logic [2:0] POS_TYPE   = 3'd2;
  localparam logic [2:0] POS_LEN_LO = 3'd3;
  localparam logic [2:0] POS_LEN_HI = 3'd4;
  localparam logic [2:0] POS_ID_LO  = 3'd5;
  localparam logic [2:0] POS_ID_HI  = 3'd6;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] msg_type;
    logic [ID_W-1:0]   msg_id;
    logic [PLEN_W-1:0] payload_len;
    logic              wake;
    logic              last;
  } res_t;

endpackage

>>> hw/rtl/mic_sfp_in_if.sv
// ----------------------------------------------------------------------------
// mic_sfp_in_if
// Byte channel into the parser: valid, ready and one received byte.
// ----------------------------------------------------------------------------
interface mic_sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/mic_sfp_out_if.sv
// ----------------------------------------------------------------------------
// mic_sfp_out_if
// Result channel out of the parser: valid, ready and one result.
// ----------------------------------------------------------------------------
interface mic_sfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  msg_type;
  logic [15:0] msg_id;
  logic [9:0]  payload_len;
  logic        wake;
  logic        last;

  modport source (output valid, output kind, output data_byte, output msg_type,
                  output msg_id, output payload_len, output wake, output last,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input msg_type,
                  input msg_id, input payload_len, input wake, input last,
                  output ready);
endinterface

>>> hw/rtl/mic_sfp_core.sv
// ----------------------------------------------------------------------------
// mic_sfp_core
// Frame state, header capture, checksum and result build for one byte.
// ----------------------------------------------------------------------------
module mic_sfp_core
  import mic_sfp_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_wr_t           cfg_wr,
  input  logic              byte_fire,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              res_valid,
  output res_t              res
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic [BYTE_W-1:0] header_r, user_id_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;

  logic [TOT_W-1:0]  tot_calc;
  logic [BYTE_W-1:0] expect_sum;
  logic              good;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RST;
      user_id_r <= USER_ID_RST;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.idx)
        REG_HEADER:  header_r  <= cfg_wr.data;
        REG_USER_ID: user_id_r <= cfg_wr.data;
        default:     header_r  <= header_r;
      endcase
    end
  end

  always_comb begin
    count_nxt  = count_r;
    total_nxt  = total_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    id_nxt     = id_r;
    sum_nxt    = sum_r;
    res_valid  = 1'b0;
    res.kind        = KIND_PAYLOAD;
    res.data_byte   = '0;
    res.payload_len = length_r[PLEN_W-1:0];
    res.wake        = 1'b0;
    res.last        = 1'b0;
    tot_calc   = '0;
    expect_sum = ~sum_r + 8'd1;
    good       = (rx_byte == expect_sum);

    if (byte_fire) begin
      priority if (count_r == '0) begin
        if (rx_byte == header_r) begin
          sum_nxt   = rx_byte;
          count_nxt = CNT_W'(1);
        end
      end else if (count_r == CNT_W'(1)) begin
        if (rx_byte == user_id_r) begin
          sum_nxt   = sum_r + rx_byte;
          count_nxt = CNT_W'(2);
        end else begin
          count_nxt = '0;
          total_nxt = '0;
          sum_nxt   = '0;
        end
      end else if (count_r < CNT_W'(HDR_BYTES)) begin
        unique case (count_r[2:0])
          POS_TYPE:   type_nxt   = rx_byte;
          POS_LEN_LO: length_nxt = {8'd0, rx_byte};
          POS_LEN_HI: length_nxt = {rx_byte, length_r[7:0]};
          POS_ID_LO:  id_nxt     = {8'd0, rx_byte};
          default:    id_nxt     = {rx_byte, id_r[7:0]};
        endcase
        sum_nxt   = sum_r + rx_byte;
        count_nxt = count_r + CNT_W'(1);
        if (count_r == CNT_W'(HDR_BYTES - 1)) begin
          tot_calc = {2'd0, length_nxt[14:0]} + TOT_W'(HDR_BYTES + 1);
          if (length_nxt[15] || (tot_calc > TOT_W'(MAX_FRAME))) begin
            res_valid       = 1'b1;
            res.kind        = KIND_DROP;
            res.payload_len = '0;
            res.last        = 1'b1;
            count_nxt       = '0;
            total_nxt       = '0;
            sum_nxt         = '0;
          end else begin
            total_nxt = tot_calc[CNT_W-1:0];
          end
        end
      end else if (({1'b0, count_r} + (CNT_W+1)'(1)) < {1'b0, total_r}) begin
        sum_nxt       = sum_r + rx_byte;
        count_nxt     = count_r + CNT_W'(1);
        res_valid     = 1'b1;
        res.data_byte = rx_byte;
      end else begin
        res_valid = 1'b1;
        res.kind  = good ? KIND_GOOD : KIND_BAD;
        res.wake  = good && (type_r == WAKE_TYPE);
        res.last  = 1'b1;
        count_nxt = '0;
        total_nxt = '0;
        sum_nxt   = '0;
      end
    end

    res.msg_type = type_nxt;
    res.msg_id   = id_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      total_r  <= '0;
      type_r   <= '0;
      length_r <= '0;
      id_r     <= '0;
      sum_r    <= '0;
    end else begin
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      type_r   <= type_nxt;
      length_r <= length_nxt;
      id_r     <= id_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

>>> hw/rtl/mic_sfp_obuf.sv
// ----------------------------------------------------------------------------
// mic_sfp_obuf
// Two-entry result buffer; decouples the parser from output back-pressure.
// ----------------------------------------------------------------------------
module mic_sfp_obuf
  import mic_sfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  res_t         push_res,
  output logic         full,
  mic_sfp_out_if.source out_ch
);

  res_t       buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;
  res_t       head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign full = (count_r == 2'd2);
  assign head = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_ch.valid       = (count_r != 2'd0);
  assign out_ch.kind        = head.kind;
  assign out_ch.data_byte   = head.data_byte;
  assign out_ch.msg_type    = head.msg_type;
  assign out_ch.msg_id      = head.msg_id;
  assign out_ch.payload_len = head.payload_len;
  assign out_ch.wake        = head.wake;
  assign out_ch.last        = head.last;

endmodule

>>> hw/rtl/mic_serial_frame_parser.sv
// ----------------------------------------------------------------------------
// mic_serial_frame_parser
// Serial frame parser: header and user id hunt, header capture, payload
// pass-through, checksum check, oversize drop and wake report.
// ----------------------------------------------------------------------------
// One received byte per transaction, one byte per cycle sustained while the
// output buffer is not full. A byte goes into an input register and is
// parsed from there once the output buffer has room. Its result, if any,
// lands in a two-entry output buffer at the next edge, and is shown once
// the results ahead of it have been taken. Input is stalled only while the
// input register holds a byte and the output buffer is full. Frames longer
// than MAX_FRAME bytes, or whose length has bit 15 set, end with a drop
// result on the seventh byte. Write header_byte (index 0) and user_id_byte
// (index 1) only when idle.
module mic_serial_frame_parser
  import mic_sfp_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  mic_sfp_in_if.sink           in_ch,
  mic_sfp_out_if.source        out_ch
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_fire;
  logic              obuf_full;
  logic              res_valid;
  res_t              res;
  cfg_wr_t           cfg_wr;

  assign cfg_wr      = '{we: cfg_we, idx: cfg_idx, data: cfg_wdata};
  assign s1_fire     = s1_valid_r && !obuf_full;
  assign in_ch.ready = !s1_valid_r || !obuf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  mic_sfp_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .byte_fire (s1_fire),
    .rx_byte   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mic_sfp_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_res (res),
    .full     (obuf_full),
    .out_ch   (out_ch)
  );

endmodule

>>> hw/rtl/mic_sfp_chk.sv
// ----------------------------------------------------------------------------
// mic_sfp_chk
// Port-level checks of the serial frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module mic_sfp_chk
  import mic_sfp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [BYTE_W-1:0] out_data_byte,
  input logic [BYTE_W-1:0] out_msg_type,
  input logic [ID_W-1:0]   out_msg_id,
  input logic [PLEN_W-1:0] out_payload_len,
  input logic              out_wake,
  input logic              out_last
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_msg_id) && $stable(out_last))
    else $error("stalled result changed");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_PAYLOAD) |-> out_last && (out_data_byte == '0))
    else $error("frame end result malformed");

  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake |-> (out_kind == KIND_GOOD) && (out_msg_type == WAKE_TYPE))
    else $error("wake on a frame that is not a good wake frame");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DROP) |-> (out_payload_len == '0) && !out_wake)
    else $error("drop result carries length or wake");

endmodule

bind mic_serial_frame_parser mic_sfp_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_data_byte   (out_ch.data_byte),
  .out_msg_type    (out_ch.msg_type),
  .out_msg_id      (out_ch.msg_id),
  .out_payload_len (out_ch.payload_len),
  .out_wake        (out_ch.wake),
  .out_last        (out_ch.last)
);

>>> tb/sv/tb_mic_serial_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_mic_serial_frame_parser
// Self-checking bench for the serial frame parser. A byte queue feeds a
// driver at the falling edge; a monitor at the rising edge runs a frame
// predictor on each accepted byte and checks every result transaction
// against the oldest predicted one. Header and user id are reprogrammed
// between phases, and the sink is held off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_mic_serial_frame_parser;
  import mic_sfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  mic_sfp_in_if  in_if ();
  mic_sfp_out_if out_if ();

  mic_serial_frame_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // stimulus and expectation stores
  logic [BYTE_W-1:0] byte_q [$];
  res_t              frame_q [$];

  int  src_idle = 7;
  int  snk_idle = 59;
  int  hold_left = 0;
  int  cycle_cnt = 0;
  int  err_cnt = 0;
  bit  in_fire = 1'b0;

  // frame predictor state
  logic [BYTE_W-1:0] hdr_cfg = HEADER_RST;
  logic [BYTE_W-1:0] uid_cfg = USER_ID_RST;
  logic [10:0]       pos = '0;
  logic [TOT_W-1:0]  total = '0;
  logic [BYTE_W-1:0] typ = '0;
  logic [LEN_W-1:0]  len = '0;
  logic [ID_W-1:0]   id = '0;
  logic [BYTE_W-1:0] sum = '0;

  initial begin
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready  = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t make_res(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] d,
                                    input logic w, input logic l);
    res_t r;
    r.kind        = k;
    r.data_byte   = d;
    r.msg_type    = typ;
    r.msg_id      = id;
    r.payload_len = (k == KIND_DROP) ? '0 : len[PLEN_W-1:0];
    r.wake        = w;
    r.last        = l;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output res_t r);
    logic [BYTE_W-1:0] chk;
    bit                good;
    r = '0;
    parse_byte = 1'b0;
    if (pos == '0) begin
      if (b == hdr_cfg) begin
        sum = b;
        pos = 11'd1;
      end
    end else if (pos == 11'd1) begin
      if (b == uid_cfg) begin
        sum = sum + b;
        pos = 11'd2;
      end else begin
        pos = '0; total = '0; sum = '0;
      end
    end else if (pos < HDR_BYTES) begin
      case (pos[2:0])
        POS_TYPE:   typ = b;
        POS_LEN_LO: len = {8'h00, b};
        POS_LEN_HI: len[15:8] = b;
        POS_ID_LO:  id = {8'h00, b};
        default:    id[15:8] = b;
      endcase
      sum = sum + b;
      pos = pos + 11'd1;
      if (pos == HDR_BYTES) begin
        total = {2'b00, len[14:0]} + TOT_W'(HDR_BYTES + 1);
        if (len[15] || total > MAX_FRAME_DEF) begin
          r = make_res(KIND_DROP, '0, 1'b0, 1'b1);
          parse_byte = 1'b1;
          pos = '0; total = '0; sum = '0;
        end
      end
    end else if ({6'd0, pos} + 1 < total) begin
      sum = sum + b;
      pos = pos + 11'd1;
      r = make_res(KIND_PAYLOAD, b, 1'b0, 1'b0);
      parse_byte = 1'b1;
    end else begin
      chk = ~sum + 8'd1;
      good = (b == chk);
      r = make_res(good ? KIND_GOOD : KIND_BAD, '0, good && typ == WAKE_TYPE, 1'b1);
      parse_byte = 1'b1;
      pos = '0; total = '0; sum = '0;
    end
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // driver: present the next byte once the previous transaction has gone
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_fire)) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= src_idle) begin
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= byte_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle);
  end

  always @(negedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // monitor: predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    res_t want_r;
    res_t got_r;
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      in_fire <= rst_n && in_if.valid && in_if.ready;
      if (rst_n && in_if.valid && in_if.ready) begin
        if (parse_byte(in_if.rx_byte, want_r)) frame_q.push_back(want_r);
      end
      if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
        got_r = {out_if.kind, out_if.data_byte, out_if.msg_type, out_if.msg_id,
                 out_if.payload_len, out_if.wake, out_if.last};
        if (frame_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result %h", got_r));
        end else begin
          want_r = frame_q.pop_front();
          check_field("kind", 16'(got_r.kind), 16'(want_r.kind));
          check_field("data_byte", 16'(got_r.data_byte), 16'(want_r.data_byte));
          check_field("msg_type", 16'(got_r.msg_type), 16'(want_r.msg_type));
          check_field("msg_id", got_r.msg_id, want_r.msg_id);
          check_field("payload_len", 16'(got_r.payload_len), 16'(want_r.payload_len));
          check_field("wake", 16'(got_r.wake), 16'(want_r.wake));
          check_field("last", 16'(got_r.last), 16'(want_r.last));
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == REG_HEADER) hdr_cfg = data;
    else uid_cfg = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (byte_q.size() != 0 || in_if.valid || frame_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_frame(input logic [BYTE_W-1:0] mtype, input logic [LEN_W-1:0] flen,
                            input bit corrupt);
    logic [BYTE_W-1:0] hb [7];
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] b;
    s = '0;
    hb = '{hdr_cfg, uid_cfg, mtype, flen[7:0], flen[15:8], 8'($urandom), 8'($urandom)};
    for (int i = 0; i < HDR_BYTES; i++) begin
      byte_q.push_back(hb[i]);
      s = s + hb[i];
    end
    if (flen[15] || flen + 8 > MAX_FRAME_DEF) return;
    for (int i = 0; i < flen; i++) begin
      b = 8'($urandom);
      byte_q.push_back(b);
      s = s + b;
    end
    b = ~s + 8'd1;
    if (corrupt) b = b ^ 8'($urandom_range(1, 255));
    byte_q.push_back(b);
  endtask

  task automatic push_traffic(input int nbytes);
    int                start;
    int                sel;
    logic [LEN_W-1:0]  flen;
    logic [BYTE_W-1:0] b;
    start = byte_q.size();
    while (byte_q.size() - start < nbytes) begin
      sel = $urandom_range(99);
      if (sel < 72) begin
        flen = ($urandom_range(19) == 0) ? 16'($urandom_range(13, 60))
                                          : 16'($urandom_range(0, 12));
        b = ($urandom_range(3) == 0) ? WAKE_TYPE : 8'($urandom);
        push_frame(b, flen, $urandom_range(99) < 15);
      end else if (sel < 82) begin
        flen = $urandom_range(1) ? 16'($urandom_range(MAX_FRAME_DEF - 7, 16'h7FFF))
                                 : (16'h8000 | 16'($urandom));
        push_frame(8'($urandom), flen, 1'b0);
      end else if (sel < 90) begin
        byte_q.push_back(hdr_cfg);
        b = 8'($urandom);
        if (b == uid_cfg) b = ~b;
        byte_q.push_back(b);
      end else begin
        byte_q.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme noise, user id mismatch on a header value, wake
    // frame with zero length good and bad, both kinds of oversize drop
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    byte_q.push_back(hdr_cfg);
    byte_q.push_back(hdr_cfg);
    push_frame(WAKE_TYPE, 16'd0, 1'b0);
    push_frame(WAKE_TYPE, 16'd0, 1'b1);
    push_frame(8'hFF, 16'(MAX_FRAME_DEF - 7), 1'b0);
    push_frame(8'h00, 16'hFFFF, 1'b0);
    push_traffic(280);
    repeat (100) @(posedge clk);
    hold_left = 500;
    drain();

    write_reg(REG_HEADER, 8'h00);
    write_reg(REG_USER_ID, 8'hFF);
    @(posedge clk);
    src_idle = 59;
    snk_idle = 7;
    push_traffic(280);
    drain();

    write_reg(REG_HEADER, 8'hFF);
    write_reg(REG_USER_ID, 8'h00);
    @(posedge clk);
    src_idle = 0;
    snk_idle = 0;
    push_traffic(150);
    drain();

    write_reg(REG_HEADER, 8'($urandom));
    write_reg(REG_USER_ID, 8'($urandom));
    @(posedge clk);
    push_traffic(150);
    drain();

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && frame_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
